// ===== sv/dnb_pkg.sv =====
// Shared types and constants for the direct-summation acceleration block.
`default_nettype none
package dnb_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET_X     = 3'd0;
  localparam logic [2:0] REG_TARGET_Y     = 3'd1;
  localparam logic [2:0] REG_TARGET_Z     = 3'd2;
  localparam logic [2:0] REG_TARGET_INDEX = 3'd3;
  localparam logic [2:0] REG_GAIN         = 3'd4;

  localparam logic [31:0] GAIN_RESET = 32'h0001_0000;
  localparam logic [63:0] POS_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN    = 64'h8000_0000_0000_0000;

  // Sequencer last-step indexes (each phase counts from 0 up to its value)
  localparam logic [5:0] MUL_LAST   = 6'd5;
  localparam logic [5:0] ROOT_LAST  = 6'd48;
  localparam logic [5:0] DEN_LAST   = 6'd3;
  localparam logic [5:0] DIV_LAST   = 6'd62;
  localparam logic [5:0] SCALE_LAST = 6'd8;

  // Shared multiplier operand selects in the per-source multiply phase
  localparam logic [2:0] MS_SQ_X  = 3'd0;
  localparam logic [2:0] MS_SQ_Y  = 3'd1;
  localparam logic [2:0] MS_SQ_Z  = 3'd2;
  localparam logic [2:0] MS_TOP_X = 3'd3;
  localparam logic [2:0] MS_TOP_Y = 3'd4;
  localparam logic [2:0] MS_TOP_Z = 3'd5;

  // Gain scaling phases per axis
  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       zero_chk;
    logic       root_en;
    logic       den_en;
    logic [1:0] den_sel;
    logic       div_init;
    logic       div_en;
    logic       acc_en;
    logic       scale_en;
    logic [1:0] scale_axis;
    logic [1:0] scale_ph;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic r2_zero;
    logic final_in;
    logic final_src;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/dnb_ctrl.sv =====
// Sequencer that steps the datapath through one source and the final scaling.
`default_nettype none
module dnb_ctrl import dnb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_MUL   = 10'b00_0000_0010,
    ST_ROOT0 = 10'b00_0000_0100,
    ST_ROOT  = 10'b00_0000_1000,
    ST_DEN   = 10'b00_0001_0000,
    ST_DIV0  = 10'b00_0010_0000,
    ST_DIV   = 10'b00_0100_0000,
    ST_ACC   = 10'b00_1000_0000,
    ST_FIN   = 10'b01_0000_0000,
    ST_SCALE = 10'b10_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_o     = '0;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          if (status_i.hit) begin
            state_nxt = status_i.final_in ? ST_FIN : ST_IDLE;
          end else begin
            state_nxt = ST_MUL;
            cnt_nxt   = '0;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_r[2:0];
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_ROOT0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_ROOT0: begin
        cmd_o.zero_chk = 1'b1;
        if (status_i.r2_zero) begin
          state_nxt = status_i.final_src ? ST_FIN : ST_IDLE;
        end else begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end
      end
      ST_ROOT: begin
        cmd_o.root_en = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_DEN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_DEN: begin
        cmd_o.den_en  = 1'b1;
        cmd_o.den_sel = cnt_r[1:0];
        if (cnt_r == DEN_LAST) begin
          state_nxt = ST_DIV0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_DIV0: begin
        cmd_o.div_init = 1'b1;
        state_nxt      = ST_DIV;
        cnt_nxt        = '0;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_ACC;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_nxt    = status_i.final_src ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          state_nxt = ST_SCALE;
          cnt_nxt   = '0;
        end
      end
      ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        priority if (cnt_r >= 6'd6) begin
          cmd_o.scale_axis = 2'd2;
          cmd_o.scale_ph   = 2'(cnt_r - 6'd6);
        end else if (cnt_r >= 6'd3) begin
          cmd_o.scale_axis = 2'd1;
          cmd_o.scale_ph   = 2'(cnt_r - 6'd3);
        end else begin
          cmd_o.scale_axis = 2'd0;
          cmd_o.scale_ph   = cnt_r[1:0];
        end
        if (cnt_r == SCALE_LAST) begin
          cmd_o.emit = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_div_after_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.div_init |-> $past(state_r) == ST_DEN)
    else $error("division started without a denominator pass");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |=> (state_r == ST_IDLE && cnt_r == SCALE_LAST))
    else $error("sequencer did not return to idle after emitting");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

endmodule
`default_nettype wire

// ===== sv/dnb_dp.sv =====
// Datapath: config registers, shared multiplier, root and divide units, sums, output.
`default_nettype none
module dnb_dp import dnb_pkg::*; #(
  parameter int MAX_SOURCES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        in_source_mass,
  input  logic signed [31:0] in_source_x,
  input  logic signed [31:0] in_source_y,
  input  logic signed [31:0] in_source_z,
  input  logic               in_final_source,
  output logic signed [63:0] out_accel_x,
  output logic signed [63:0] out_accel_y,
  output logic signed [63:0] out_accel_z,
  output logic               out_saturated,
  output logic               out_coincident,
  output logic               out_valid,
  input  logic               out_ready,
  input  cmd_t               cmd_i,
  output status_t            status_o
);

  localparam int CW   = $clog2(MAX_SOURCES);
  localparam int CMPW = (CW > 10) ? CW : 10;

  // Configuration
  logic [2:0][31:0] tgt_r;
  logic [9:0]       tgt_idx_r;
  logic [31:0]      gain_r;

  // Per-source operands
  logic [CW-1:0]    cnt_r;
  logic [31:0]      mass_r;
  logic [2:0][31:0] mag_r;
  logic [2:0]       sgn_r;
  logic             final_r;
  logic [65:0]      r2_r;
  logic [2:0][63:0] top_r;
  logic [115:0]     den_r;

  // Square root unit
  logic [97:0] sq_rem_r, sq_res_r, sq_bit_r;

  // Divider lanes
  logic [2:0][115:0] rem_r;
  logic [2:0][62:0]  quo_r;
  logic [2:0]        tsat_r;

  // Sums and flags
  logic [2:0][63:0] sum_r;
  logic             sat_seen_r, zero_seen_r;

  // Scaling and output
  logic [96:0]      sp_r;
  logic [2:0][63:0] out_acc_r;
  logic             out_sat_r, out_coin_r, out_valid_r;

  logic [2:0][31:0] src_pos;
  logic [2:0][31:0] dmag;
  logic [2:0]       dneg;
  logic [32:0]      dval [3];
  logic [32:0]      mul_a, mul_b;
  logic [65:0]      prod;
  logic [63:0]      ssel, smag;
  logic             sneg;
  logic [48:0]      root_s;

  assign src_pos = {in_source_z, in_source_y, in_source_x};
  assign root_s  = sq_res_r[48:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dval[k] = {src_pos[k][31], src_pos[k]} - {tgt_r[k][31], tgt_r[k]};
      dneg[k] = dval[k][32];
      dmag[k] = dneg[k] ? 32'(33'd0 - dval[k]) : dval[k][31:0];
    end
  end

  // Magnitude of the sum under scaling
  always_comb begin
    ssel = sum_r[cmd_i.scale_axis];
    sneg = ssel[63];
    smag = sneg ? (64'd0 - ssel) : ssel;
  end

  // Shared 33x33 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MS_SQ_X:  begin mul_a = {1'b0, mag_r[0]}; mul_b = {1'b0, mag_r[0]}; end
        MS_SQ_Y:  begin mul_a = {1'b0, mag_r[1]}; mul_b = {1'b0, mag_r[1]}; end
        MS_SQ_Z:  begin mul_a = {1'b0, mag_r[2]}; mul_b = {1'b0, mag_r[2]}; end
        MS_TOP_X: begin mul_a = {1'b0, mass_r};   mul_b = {1'b0, mag_r[0]}; end
        MS_TOP_Y: begin mul_a = {1'b0, mass_r};   mul_b = {1'b0, mag_r[1]}; end
        MS_TOP_Z: begin mul_a = {1'b0, mass_r};   mul_b = {1'b0, mag_r[2]}; end
        default:  begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd_i.den_en) begin
      mul_a = cmd_i.den_sel[1] ? r2_r[65:33] : r2_r[32:0];
      mul_b = cmd_i.den_sel[0] ? {17'd0, root_s[48:33]} : root_s[32:0];
    end else if (cmd_i.scale_en) begin
      mul_a = (cmd_i.scale_ph == PH_HI) ? {1'b0, smag[63:32]} : {1'b0, smag[31:0]};
      mul_b = {1'b0, gain_r};
    end
  end

  assign prod = mul_a * mul_b;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r     <= '0;
      tgt_idx_r <= '0;
      gain_r    <= GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_X:     tgt_r[0]  <= cfg_data;
        REG_TARGET_Y:     tgt_r[1]  <= cfg_data;
        REG_TARGET_Z:     tgt_r[2]  <= cfg_data;
        REG_TARGET_INDEX: tgt_idx_r <= cfg_data[9:0];
        REG_GAIN:         gain_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Source counter and operand capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      final_r <= 1'b0;
    end else if (cmd_i.load) begin
      final_r <= in_final_source;
      if (in_final_source || cnt_r == CW'(MAX_SOURCES - 1)) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mass_r <= in_source_mass;
      mag_r  <= dmag;
      sgn_r  <= dneg;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MS_SQ_X:  r2_r     <= prod;
        MS_SQ_Y:  r2_r     <= r2_r + prod;
        MS_SQ_Z:  r2_r     <= r2_r + prod;
        MS_TOP_X: top_r[0] <= prod[63:0];
        MS_TOP_Y: top_r[1] <= prod[63:0];
        MS_TOP_Z: top_r[2] <= prod[63:0];
        default: ;
      endcase
    end
    // Denominator R2 * S from four partial products
    if (cmd_i.den_en) begin
      unique case (cmd_i.den_sel)
        2'd0: den_r <= {50'd0, prod};
        2'd1: den_r <= den_r + {17'd0, prod, 33'd0};
        2'd2: den_r <= den_r + {17'd0, prod, 33'd0};
        2'd3: den_r <= den_r + {prod[49:0], 66'd0};
        default: ;
      endcase
    end
  end

  // Square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (cmd_i.zero_chk) begin
      sq_rem_r <= {r2_r, 32'd0};
      sq_res_r <= '0;
      sq_bit_r <= 98'd1 << 96;
    end else if (cmd_i.root_en) begin
      if (sq_rem_r >= sq_res_r + sq_bit_r) begin
        sq_rem_r <= sq_rem_r - (sq_res_r + sq_bit_r);
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  // Three divider lanes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.div_init) begin
        rem_r[k]  <= {51'd0, top_r[k], 1'b0};
        tsat_r[k] <= ({51'd0, top_r[k], 1'b0} >= den_r);
        quo_r[k]  <= '0;
      end else if (cmd_i.div_en) begin
        if ({rem_r[k][114:0], 1'b0} >= den_r) begin
          rem_r[k] <= {rem_r[k][114:0], 1'b0} - den_r;
          quo_r[k] <= {quo_r[k][61:0], 1'b1};
        end else begin
          rem_r[k] <= {rem_r[k][114:0], 1'b0};
          quo_r[k] <= {quo_r[k][61:0], 1'b0};
        end
      end
    end
  end

  // Saturating sums
  logic [2:0][63:0] acc_new;
  logic [2:0]       acc_flag;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [63:0] tmag, term, s;
      logic        ovf;
      tmag = tsat_r[k] ? POS_MAX : {1'b0, quo_r[k]};
      term = sgn_r[k] ? (64'd0 - tmag) : tmag;
      s    = sum_r[k] + term;
      ovf  = ~(sum_r[k][63] ^ term[63]) & (sum_r[k][63] ^ s[63]);
      acc_new[k]  = ovf ? (sum_r[k][63] ? NEG_MIN : POS_MAX) : s;
      acc_flag[k] = ovf | tsat_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      sat_seen_r  <= 1'b0;
      zero_seen_r <= 1'b0;
    end else if (cmd_i.emit) begin
      sum_r       <= '0;
      sat_seen_r  <= 1'b0;
      zero_seen_r <= 1'b0;
    end else begin
      if (cmd_i.zero_chk && r2_r == '0) begin
        zero_seen_r <= 1'b1;
      end
      if (cmd_i.acc_en) begin
        sum_r      <= acc_new;
        sat_seen_r <= sat_seen_r | (|acc_flag);
      end
    end
  end

  // Gain scaling into the output register
  logic [63:0] sc_lim, sc_val;
  logic        sc_ov;
  always_comb begin
    sc_lim = sneg ? NEG_MIN : POS_MAX;
    sc_ov  = (sp_r[96:80] != '0) || (sp_r[79:16] > sc_lim);
    sc_val = sc_ov ? sc_lim : sp_r[79:16];
    sc_val = sneg ? (64'd0 - sc_val) : sc_val;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.scale_en) begin
      unique case (cmd_i.scale_ph)
        PH_LO:  sp_r <= 97'(prod);
        PH_HI:  sp_r <= sp_r + {prod[64:0], 32'd0};
        PH_FIN: begin
          out_acc_r[cmd_i.scale_axis] <= sc_val;
          out_sat_r <= ((cmd_i.scale_axis == 2'd0) ? sat_seen_r : out_sat_r) | sc_ov;
        end
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_coin_r <= zero_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_accel_x    = $signed(out_acc_r[0]);
  assign out_accel_y    = $signed(out_acc_r[1]);
  assign out_accel_z    = $signed(out_acc_r[2]);
  assign out_saturated  = out_sat_r;
  assign out_coincident = out_coin_r;
  assign out_valid      = out_valid_r;

  assign status_o.hit       = (CMPW'(cnt_r) == CMPW'(tgt_idx_r));
  assign status_o.r2_zero   = (r2_r == '0);
  assign status_o.final_in  = in_final_source;
  assign status_o.final_src = final_r;
  assign status_o.out_free  = !out_valid_r || out_ready;

  a_scale_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.scale_en |-> !out_valid_r)
    else $error("output register overwritten while a beat is pending");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |=> (sum_r == '0 && !sat_seen_r && !zero_seen_r))
    else $error("sums or flags not cleared after emit");

  a_final_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load && in_final_source |=> cnt_r == '0)
    else $error("source counter not cleared by the last source");

endmodule
`default_nettype wire

// ===== sv/direct_nbody_accel_sum.sv =====
// Top level of the direct-summation gravitational acceleration block.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat per source particle, mass and
//    position plus in_final_source on the last source of a set. Sources are
//    numbered from 0; the one whose number equals target_index is skipped.
//  - Output channel (out_valid/out_ready): one beat per set, after the last
//    source, with the three accelerations scaled by gain and two flags.
//  - Config channel (cfg_valid/cfg_ready, always ready): write the target
//    position, target_index and gain between sets while the block is idle.
//  - Pacing: a new source is not taken until the last one is done; the time
//    is set by the 49-step square root and the 63-step restoring divide
//    (three axes side by side); a skipped source needs neither. The last
//    source adds a wait state plus gain scaling (low, high and final phase
//    per axis) on the shared 33x33 multiplier.
//  - The result sits in an output register; the next set's sources are taken
//    while it waits. If the receiver stalls, the next result holds off in a
//    wait state and in_ready stays low until the register frees.
//  - Reset (rst_n low, synchronous) clears sums, flags, counter and the
//    config registers (gain to 1.0).
`default_nettype none
module direct_nbody_accel_sum import dnb_pkg::*; #(
  parameter int MAX_SOURCES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_source_mass,
  input  logic signed [31:0] in_source_x,
  input  logic signed [31:0] in_source_y,
  input  logic signed [31:0] in_source_z,
  input  logic               in_final_source,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_accel_x,
  output logic signed [63:0] out_accel_y,
  output logic signed [63:0] out_accel_z,
  output logic               out_saturated,
  output logic               out_coincident
);

  cmd_t    cmd;
  status_t status;

  // Config registers accept a beat every cycle
  assign cfg_ready = 1'b1;

  dnb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dnb_dp #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_source_mass  (in_source_mass),
    .in_source_x     (in_source_x),
    .in_source_y     (in_source_y),
    .in_source_z     (in_source_z),
    .in_final_source (in_final_source),
    .out_accel_x     (out_accel_x),
    .out_accel_y     (out_accel_y),
    .out_accel_z     (out_accel_z),
    .out_saturated   (out_saturated),
    .out_coincident  (out_coincident),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule
`default_nettype wire
